[rtl/ffea_pkg.sv]
// Shared types and codes for the first-fit extent allocator.
`timescale 1ns / 1ps
package ffea_pkg;

  localparam int FIELD_W = 32;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_CLAIM = 2'd1,
    OP_FREE  = 2'd2,
    OP_PURGE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_ZERO    = 3'd2,
    ST_OVERLAP = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // What a cell does in the apply cycle
  typedef enum logic [2:0] {
    CK_NONE    = 3'd0,
    CK_PURGE   = 3'd1,
    CK_TAKE    = 3'd2,
    CK_DROP    = 3'd3,
    CK_MERGE2  = 3'd4,
    CK_GROW_LO = 3'd5,
    CK_GROW_HI = 3'd6,
    CK_INSERT  = 3'd7
  } cell_kind_t;

  // Per-cell compare results against the current item
  typedef struct packed {
    logic fit;     // length >= item length
    logic eqlen;   // length == item length
    logic at;      // start == item address
    logic le;      // valid and start <= item address
    logic end_gt;  // extent end > item address
    logic end_eq;  // extent end == item address
    logic st_lt;   // start < item end
    logic st_eq;   // start == item end
  } cell_flags_t;

  typedef struct packed {
    cell_kind_t kind;
    logic       sel;
    logic       shift;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_APPLY  = 4'b1000
  } fsm_t;

endpackage

[rtl/ffea_req_if.sv]
// Request channel: opcode, address and length with valid/ready.
`timescale 1ns / 1ps
interface ffea_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] address;
  logic [31:0] length;

  modport source (output valid, output opcode, output address, output length, input ready);
  modport sink   (input valid, input opcode, input address, input length, output ready);
endinterface

[rtl/ffea_rsp_if.sv]
// Result channel: granted address and status with valid/ready.
`timescale 1ns / 1ps
interface ffea_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [2:0]  status;

  modport source (output valid, output result_address, output status, input ready);
  modport sink   (input valid, input result_address, input status, output ready);
endinterface

[rtl/ffea_cell.sv]
// One table cell: holds a single free extent and shifts with its neighbours.
`timescale 1ns / 1ps
module ffea_cell #(
  parameter int ADDR_BITS = 32,
  localparam int LW = ADDR_BITS + 1,
  localparam int EW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   eval_en,
  input  logic [ADDR_BITS-1:0]   req_addr,
  input  logic [EW-1:0]          req_len,
  input  logic [EW-1:0]          req_end,
  input  ffea_pkg::cell_ctl_t    ctl,
  input  logic                   up_valid,
  input  logic [ADDR_BITS-1:0]   up_start,
  input  logic [LW-1:0]          up_length,
  input  logic [LW-1:0]          up_end,
  input  logic                   dn_valid,
  input  logic [ADDR_BITS-1:0]   dn_start,
  input  logic [LW-1:0]          dn_length,
  output logic                   valid,
  output logic [ADDR_BITS-1:0]   start,
  output logic [LW-1:0]          length,
  output logic [LW-1:0]          ext_end,
  output ffea_pkg::cell_flags_t  flags
);
  import ffea_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [ADDR_BITS-1:0] start_r, start_nxt;
  logic [LW-1:0]        length_r, length_nxt;
  logic [LW-1:0]        end_r;
  cell_flags_t          flags_r, flags_nxt;
  logic [EW-1:0]        start_ext, length_ext, end_ext, addr_ext;
  logic [LW-1:0]        sum_end;

  assign start_ext  = EW'(start_r);
  assign length_ext = EW'(length_r);
  assign addr_ext   = EW'(req_addr);
  assign sum_end    = LW'(start_r) + length_r;
  assign end_ext    = EW'(sum_end);

  always_comb begin
    flags_nxt.fit    = valid_r && (length_ext >= req_len);
    flags_nxt.eqlen  = length_ext == req_len;
    flags_nxt.at     = start_r == req_addr;
    flags_nxt.le     = valid_r && (start_r <= req_addr);
    flags_nxt.end_gt = end_ext > addr_ext;
    flags_nxt.end_eq = end_ext == addr_ext;
    flags_nxt.st_lt  = start_ext < req_end;
    flags_nxt.st_eq  = start_ext == req_end;
  end

  always_comb begin
    valid_nxt  = valid_r;
    start_nxt  = start_r;
    length_nxt = length_r;
    case (ctl.kind)
      CK_PURGE: begin
        valid_nxt = 1'b0;
      end
      CK_TAKE: begin
        if (ctl.sel) begin
          start_nxt  = ADDR_BITS'(start_ext + req_len);
          length_nxt = LW'(length_ext - req_len);
        end
      end
      CK_DROP: begin
        if (ctl.shift) begin
          valid_nxt  = up_valid;
          start_nxt  = up_start;
          length_nxt = up_length;
        end
      end
      CK_MERGE2: begin
        // lower neighbour swallows the freed range and the upper extent
        if (ctl.sel) begin
          length_nxt = up_end - LW'(start_r);
        end else if (ctl.shift) begin
          valid_nxt  = up_valid;
          start_nxt  = up_start;
          length_nxt = up_length;
        end
      end
      CK_GROW_LO: begin
        if (ctl.sel) begin
          length_nxt = LW'(length_ext + req_len);
        end
      end
      CK_GROW_HI: begin
        if (ctl.sel) begin
          start_nxt  = req_addr;
          length_nxt = LW'(length_ext + req_len);
        end
      end
      CK_INSERT: begin
        if (ctl.sel) begin
          valid_nxt  = 1'b1;
          start_nxt  = req_addr;
          length_nxt = LW'(req_len);
        end else if (ctl.shift) begin
          valid_nxt  = dn_valid;
          start_nxt  = dn_start;
          length_nxt = dn_length;
        end
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    length_r <= length_nxt;
    if (eval_en) begin
      end_r   <= sum_end;
      flags_r <= flags_nxt;
    end
  end

  assign valid   = valid_r;
  assign start   = start_r;
  assign length  = length_r;
  assign ext_end = end_r;
  assign flags   = flags_r;

endmodule

[rtl/first_fit_extent_allocator.sv]
// Top level of the first-fit extent allocator: request control and a row of extent cells.
//
//   channel   dir  handshake      payload
//   in_req    in   valid/ready    opcode, address, length
//   out_rsp   out  valid/ready    result_address, status
//
// Each item passes through accept, per-cell compare, decide and apply to the cells, in that order.
// The decide step waits while a previous result sits unread in the output register.
// Reset (synchronous, rst_n low) empties the table at once; no clearing pass.
// A result is held stable until taken; the next item is accepted once the
// cells have been updated, even while that result still waits.
`timescale 1ns / 1ps
module first_fit_extent_allocator #(
  parameter int MAP_ENTRIES = 32,
  parameter int ADDR_BITS   = 32
) (
  input logic clk,
  input logic rst_n,
  ffea_req_if.sink   in_req,
  ffea_rsp_if.source out_rsp
);
  import ffea_pkg::*;

  localparam int N  = MAP_ENTRIES;
  localparam int LW = ADDR_BITS + 1;
  localparam int EW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;
  localparam logic [EW-1:0] SPACE = EW'(1) << ADDR_BITS;

  fsm_t                 state_r, state_nxt;
  opcode_t              req_op_r;
  logic [ADDR_BITS-1:0] req_addr_r;
  logic [EW-1:0]        req_len_r;
  logic [EW-1:0]        req_end;

  cell_ctl_t            ctl_r   [N];
  cell_ctl_t            ctl_nxt [N];
  logic                 go;

  logic                 out_valid_r;
  logic [FIELD_W-1:0]   out_addr_r;
  status_t              out_status_r;
  logic [ADDR_BITS-1:0] granted;
  status_t              status_d;
  cell_kind_t           kind_d;
  logic [N-1:0]         sel_d, shift_d;

  logic                 c_valid  [N];
  logic [ADDR_BITS-1:0] c_start  [N];
  logic [LW-1:0]        c_length [N];
  logic [LW-1:0]        c_end    [N];
  cell_flags_t          c_flags  [N];

  logic [N-1:0] valid_v, fit_v, eq_v, at_v, le_v, egt_v, eeq_v, slt_v, seq_v;
  logic [N-1:0] cand, first, take_mask, lo, ins, hi, ins_mask;
  logic         drop, wrap, ovl, lo_m, hi_m, full;

  assign req_end = EW'(req_addr_r) + req_len_r;

  // ---------------- cell row ----------------
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                 up_valid, dn_valid;
    logic [ADDR_BITS-1:0] up_start, dn_start;
    logic [LW-1:0]        up_length, up_end, dn_length;

    if (i == N - 1) begin : g_top
      assign up_valid  = 1'b0;
      assign up_start  = '0;
      assign up_length = '0;
      assign up_end    = '0;
    end else begin : g_mid
      assign up_valid  = c_valid[i+1];
      assign up_start  = c_start[i+1];
      assign up_length = c_length[i+1];
      assign up_end    = c_end[i+1];
    end

    if (i == 0) begin : g_bot
      assign dn_valid  = 1'b0;
      assign dn_start  = '0;
      assign dn_length = '0;
    end else begin : g_upper
      assign dn_valid  = c_valid[i-1];
      assign dn_start  = c_start[i-1];
      assign dn_length = c_length[i-1];
    end

    ffea_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .eval_en   (state_r == S_EVAL),
      .req_addr  (req_addr_r),
      .req_len   (req_len_r),
      .req_end   (req_end),
      .ctl       (ctl_r[i]),
      .up_valid  (up_valid),
      .up_start  (up_start),
      .up_length (up_length),
      .up_end    (up_end),
      .dn_valid  (dn_valid),
      .dn_start  (dn_start),
      .dn_length (dn_length),
      .valid     (c_valid[i]),
      .start     (c_start[i]),
      .length    (c_length[i]),
      .ext_end   (c_end[i]),
      .flags     (c_flags[i])
    );

    assign valid_v[i] = c_valid[i];
    assign fit_v[i]   = c_flags[i].fit;
    assign eq_v[i]    = c_flags[i].eqlen;
    assign at_v[i]    = c_flags[i].at;
    assign le_v[i]    = c_flags[i].le;
    assign egt_v[i]   = c_flags[i].end_gt;
    assign eeq_v[i]   = c_flags[i].end_eq;
    assign slt_v[i]   = c_flags[i].st_lt;
    assign seq_v[i]   = c_flags[i].st_eq;
  end

  // ---------------- decide ----------------
  assign cand      = fit_v & ((req_op_r == OP_CLAIM) ? at_v : {N{1'b1}});
  assign first     = cand & (~cand + N'(1));
  assign take_mask = ~(first - N'(1));
  assign drop      = |(first & eq_v);

  // table is sorted, so le_v is a run of ones from the bottom
  assign lo       = le_v & ~(le_v >> 1);
  assign ins      = ~le_v & {le_v[N-2:0], 1'b1};
  assign hi       = ins & valid_v;
  assign ins_mask = ~(ins - N'(1));
  assign wrap     = req_end > SPACE;
  assign ovl      = (|(lo & egt_v)) || (|(hi & slt_v));
  assign lo_m     = |(lo & eeq_v);
  assign hi_m     = |(hi & seq_v);
  assign full     = &valid_v;

  always_comb begin
    granted = '0;
    for (int i = 0; i < N; i++) begin
      if (first[i]) granted = granted | c_start[i];
    end
  end

  always_comb begin
    kind_d   = CK_NONE;
    sel_d    = '0;
    shift_d  = '0;
    status_d = ST_OK;
    if (req_op_r == OP_PURGE) begin
      kind_d = CK_PURGE;
    end else if (req_len_r == '0) begin
      status_d = ST_ZERO;
    end else if (req_op_r == OP_FREE) begin
      if (wrap || ovl) begin
        status_d = ST_OVERLAP;
      end else if (lo_m && hi_m) begin
        kind_d  = CK_MERGE2;
        sel_d   = lo;
        shift_d = ins_mask;
      end else if (lo_m) begin
        kind_d = CK_GROW_LO;
        sel_d  = lo;
      end else if (hi_m) begin
        kind_d = CK_GROW_HI;
        sel_d  = hi;
      end else if (full) begin
        status_d = ST_FULL;
      end else begin
        kind_d  = CK_INSERT;
        sel_d   = ins;
        shift_d = ins_mask;
      end
    end else if (cand == '0) begin
      status_d = ST_NOFIT;
    end else begin
      kind_d  = drop ? CK_DROP : CK_TAKE;
      sel_d   = first;
      shift_d = take_mask;
    end
  end

  // ---------------- control ----------------
  assign go = (state_r == S_DECIDE) && (!out_valid_r || out_rsp.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_req.valid) state_nxt = S_EVAL;
      S_EVAL:   state_nxt = S_DECIDE;
      S_DECIDE: if (go) state_nxt = S_APPLY;
      S_APPLY:  state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ctl_r carries a command only during the apply cycle
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ctl_nxt[i].kind  = CK_NONE;
      ctl_nxt[i].sel   = 1'b0;
      ctl_nxt[i].shift = 1'b0;
      if (go) begin
        ctl_nxt[i].kind  = kind_d;
        ctl_nxt[i].sel   = sel_d[i];
        ctl_nxt[i].shift = shift_d[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < N; i++) begin
        ctl_r[i] <= '{kind: CK_NONE, sel: 1'b0, shift: 1'b0};
      end
    end else begin
      state_r <= state_nxt;
      ctl_r   <= ctl_nxt;
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.ready && in_req.valid) begin
      req_op_r   <= opcode_t'(in_req.opcode);
      req_addr_r <= ADDR_BITS'(EW'(in_req.address));
      req_len_r  <= EW'(in_req.length);
    end
    if (go) begin
      out_status_r <= status_d;
      out_addr_r   <= (status_d == ST_OK && (req_op_r inside {OP_ALLOC, OP_CLAIM}))
                      ? FIELD_W'(granted) : '0;
    end
  end

  assign in_req.ready           = (state_r == S_IDLE);
  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.result_address = out_addr_r;
  assign out_rsp.status         = out_status_r;

endmodule

[test/first_fit_extent_allocator_tb.sv]
// Testbench for the first-fit extent allocator: random and directed items against a predictor.
`timescale 1ns / 1ps
module first_fit_extent_allocator_tb;
  import ffea_pkg::*;

  localparam int MAP_ENTRIES = 32;
  localparam int RANDOM_ITEMS = 1926;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam bit [32:0] SPACE_END = 33'h1_0000_0000;
  localparam bit [32:0] MAX_LEN = 33'h0_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] addr;
    status_t     status;
  } grant_t;

  typedef enum {MODE_MIXED, MODE_FILL, MODE_DRAIN} mode_t;

  // Free-extent table kept alongside the block, plus the results still owed
  class extent_scoreboard_t;
    bit [32:0] ext_start [MAP_ENTRIES];
    bit [32:0] ext_len [MAP_ENTRIES];
    int count;
    int mismatches;
    grant_t owed_q[$];

    function int pending();
      return owed_q.size();
    endfunction

    function void remove_entry(int k);
      for (int j = k; j + 1 < count; j++) begin
        ext_start[j] = ext_start[j + 1];
        ext_len[j] = ext_len[j + 1];
      end
      count--;
    endfunction

    function status_t release_range(logic [31:0] addr, logic [31:0] len);
      bit [32:0] fin;
      bit [32:0] lo_end;
      int pos;
      bit lo_hit;
      bit hi_hit;
      fin = {1'b0, addr} + {1'b0, len};
      lo_hit = 1'b0;
      hi_hit = 1'b0;
      if (fin > SPACE_END) return ST_OVERLAP;
      pos = 0;
      while (pos < count && ext_start[pos] <= {1'b0, addr}) pos++;
      if (pos > 0) begin
        lo_end = ext_start[pos - 1] + ext_len[pos - 1];
        if (lo_end > {1'b0, addr}) return ST_OVERLAP;
        lo_hit = (lo_end == {1'b0, addr});
      end
      if (pos < count) begin
        if (fin > ext_start[pos]) return ST_OVERLAP;
        hi_hit = (fin == ext_start[pos]);
      end
      if (lo_hit && hi_hit) begin
        ext_len[pos - 1] = ext_len[pos - 1] + {1'b0, len} + ext_len[pos];
        remove_entry(pos);
      end else if (lo_hit) begin
        ext_len[pos - 1] = ext_len[pos - 1] + {1'b0, len};
      end else if (hi_hit) begin
        ext_start[pos] = {1'b0, addr};
        ext_len[pos] = ext_len[pos] + {1'b0, len};
      end else begin
        if (count >= MAP_ENTRIES) return ST_FULL;
        for (int j = count; j > pos; j--) begin
          ext_start[j] = ext_start[j - 1];
          ext_len[j] = ext_len[j - 1];
        end
        ext_start[pos] = {1'b0, addr};
        ext_len[pos] = {1'b0, len};
        count++;
      end
      return ST_OK;
    endfunction

    function void note_request(opcode_t op, logic [31:0] addr, logic [31:0] len);
      grant_t owed;
      bit done;
      owed.addr = '0;
      owed.status = ST_OK;
      done = 1'b0;
      if (op == OP_PURGE) begin
        count = 0;
      end else if (len == '0) begin
        owed.status = ST_ZERO;
      end else if (op == OP_FREE) begin
        owed.status = release_range(addr, len);
      end else begin
        owed.status = ST_NOFIT;
        for (int k = 0; k < count; k++) begin
          if (!done && (op == OP_ALLOC || ext_start[k] == {1'b0, addr}) &&
              ext_len[k] >= {1'b0, len}) begin
            owed.addr = ext_start[k][31:0];
            owed.status = ST_OK;
            ext_start[k] = ext_start[k] + {1'b0, len};
            ext_len[k] = ext_len[k] - {1'b0, len};
            if (ext_len[k] == '0) remove_entry(k);
            done = 1'b1;
          end
        end
      end
      owed_q.push_back(owed);
    endfunction

    function void check_result(logic [31:0] addr, logic [2:0] status);
      grant_t owed;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing owed: addr %h status %0d", addr, status);
        return;
      end
      owed = owed_q.pop_front();
      if (addr !== owed.addr || status !== owed.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                   owed.addr, owed.status, addr, status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  ffea_req_if req_if ();
  ffea_rsp_if rsp_if ();

  first_fit_extent_allocator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  extent_scoreboard_t sb = new;
  int tx_idle_pct = 10;
  int rx_idle_pct = 76;
  bit hold_start = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  mode_t mode = MODE_MIXED;
  logic [31:0] win_base = '0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: random back-pressure, or a long hold-off when asked for one
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      rsp_if.ready = 1'b0;
      hold_left--;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready)
      sb.check_result(rsp_if.result_address, rsp_if.status);
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready === 1'b1) || (rsp_if.valid === 1'b1 && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("first_fit_extent_allocator_tb NOT OK");
      $finish;
    end
  end

  function automatic bit [32:0] below(bit [32:0] n);
    return {1'b0, $urandom} % n;
  endfunction

  function automatic bit [32:0] lesser(bit [32:0] a, bit [32:0] b);
    return (a < b) ? a : b;
  endfunction

  // Called on a falling edge; returns on the falling edge after acceptance
  task automatic send_request(opcode_t op, logic [31:0] addr, logic [31:0] len);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.opcode = op;
    req_if.address = addr;
    req_if.length = len;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = (req_if.ready === 1'b1);
    end
    sb.note_request(op, addr, len);
    @(negedge clk);
  endtask

  // Mostly well-formed items aimed at the gaps and extents now in the table
  task automatic pick_request(output opcode_t op, output logic [31:0] addr,
                              output logic [31:0] len);
    int roll;
    int sub;
    int k;
    int n;
    int free_share;
    bit [32:0] lo;
    bit [32:0] hi;
    bit [32:0] room;
    bit [32:0] off;
    bit [32:0] widest;
    bit [32:0] pick;
    bit [32:0] size;
    roll = $urandom_range(99);
    sub = $urandom_range(99);
    n = sb.count;
    free_share = (mode == MODE_FILL) ? 65 : (mode == MODE_DRAIN) ? 20 : 42;
    op = OP_FREE;
    pick = {1'b0, $urandom};
    size = 33'd1;
    if (roll < 5) begin
      op = opcode_t'($urandom_range(3));
      size = {1'b0, $urandom};
    end else if (roll < 7) begin
      op = OP_PURGE;
      size = 33'($urandom_range(3));
    end else if (roll < 10) begin
      op = opcode_t'($urandom_range(2));
      if (n > 0) pick = sb.ext_start[$urandom_range(n - 1)];
      size = '0;
    end else if (roll < 10 + free_share) begin
      op = OP_FREE;
      if (sub < 8) begin
        // ends at or just past the top of the space
        pick = MAX_LEN - 33'($urandom_range(15));
        size = SPACE_END - pick + 33'($urandom_range(1));
      end else if (sub < 22 && n > 0) begin
        k = $urandom_range(n - 1);
        if (sb.ext_start[k] > 16 && $urandom_range(1)) begin
          off = 33'(1 + $urandom_range(15));
          pick = sb.ext_start[k] - off;
          size = off + 33'(1 + $urandom_range(7));
        end else begin
          pick = sb.ext_start[k] + below(sb.ext_len[k]);
          size = 33'(1 + $urandom_range(63));
        end
      end else begin
        k = $urandom_range(n);
        if (n == 0) begin
          lo = {1'b0, win_base};
          hi = lesser(lo + 33'h1_0000, SPACE_END);
        end else begin
          lo = (k == 0) ? '0 : sb.ext_start[k - 1] + sb.ext_len[k - 1];
          hi = (k == n) ? SPACE_END : sb.ext_start[k];
        end
        room = hi - lo;
        if (room < 3) begin
          pick = lo;
          size = 33'd1;
        end else if (sub < ((mode == MODE_FILL) ? 80 : 45)) begin
          // clear of both neighbours: a new entry
          off = 1 + below(lesser(room - 2, 33'd512));
          size = 1 + below(lesser(room - off - 1, 33'd32));
          pick = $urandom_range(1) ? lo + off : hi - off - size;
        end else begin
          case ($urandom_range(2))
            0: begin
              size = 1 + below(lesser(room, 33'd64));
              pick = lo;
            end
            1: begin
              size = 1 + below(lesser(room, 33'd64));
              pick = hi - size;
            end
            default: begin
              size = (room <= MAX_LEN) ? room : {1'b0, $urandom | 32'd1};
              pick = lo;
            end
          endcase
        end
      end
    end else if (n == 0) begin
      op = (sub < 50) ? OP_ALLOC : OP_CLAIM;
      size = 33'(1 + $urandom_range(255));
    end else begin
      k = $urandom_range(n - 1);
      size = lesser(sb.ext_len[k], MAX_LEN);
      op = OP_ALLOC;
      if (sub < 25) begin
        // length of a whole extent: empties the first one that fits, unless that one is longer
      end else if (sub < 60) begin
        size = 1 + below(lesser(size, 33'd16));
      end else if (sub < 70) begin
        widest = '0;
        for (int j = 0; j < n; j++)
          if (sb.ext_len[j] > widest) widest = sb.ext_len[j];
        size = (widest < MAX_LEN) ? widest + 1 : {1'b0, $urandom};
      end else begin
        op = OP_CLAIM;
        pick = sb.ext_start[k];
        if (sub < 85) size = 1 + below(lesser(size, 33'd16));
        else if (sub < 95) size = size;
        else if (sub < 98) size = lesser(size + 1, MAX_LEN);
        else pick = pick + 1;
      end
    end
    addr = pick[31:0];
    len = size[31:0];
  endtask

  initial begin
    opcode_t op;
    logic [31:0] addr;
    logic [31:0] len;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.opcode = OP_ALLOC;
    req_if.address = '0;
    req_if.length = '0;
    rsp_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table, zero lengths, then build and merge extents
    send_request(OP_ALLOC, 32'h0, 32'd5);
    send_request(OP_CLAIM, 32'h0, 32'd1);
    send_request(OP_ALLOC, 32'h0, 32'd0);
    send_request(OP_CLAIM, 32'h1000, 32'd0);
    send_request(OP_FREE, 32'h0, 32'd0);
    send_request(OP_FREE, 32'h1000, 32'h100);
    send_request(OP_FREE, 32'h3000, 32'h100);
    send_request(OP_FREE, 32'h1100, 32'h80);
    send_request(OP_FREE, 32'h2F00, 32'h100);
    send_request(OP_FREE, 32'h1180, 32'h1D80);
    // overlaps below and above, wrap, then exactly up to the top
    send_request(OP_FREE, 32'h1050, 32'h10);
    send_request(OP_FREE, 32'h0F80, 32'h100);
    send_request(OP_FREE, 32'hFFFF_FF00, 32'h200);
    send_request(OP_FREE, 32'hFFFF_FF00, 32'h100);
    send_request(OP_ALLOC, 32'h0, 32'h100);
    send_request(OP_CLAIM, 32'h1100, 32'h2000);
    send_request(OP_CLAIM, 32'h1234, 32'h1);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_PURGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // whole space free in one extent
    send_request(OP_FREE, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_FREE, 32'hFFFF_FFFF, 32'h1);
    send_request(OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_CLAIM, 32'hFFFF_FFFF, 32'h1);
    send_request(OP_PURGE, 32'h0, 32'h0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        mode = mode_t'($urandom_range(2));
        case ($urandom_range(2))
          0: win_base = '0;
          1: win_base = 32'hFFFF_0000;
          default: win_base = $urandom & 32'hFFF0_0000;
        endcase
      end
      if (i == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 76;
        rx_idle_pct = 10;
      end
      if (i == RANDOM_ITEMS / 2) begin
        req_if.valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      if (i == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_start = 1'b1;
      end
      pick_request(op, addr, len);
      send_request(op, addr, len);
    end
    req_if.valid = 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0)
      $display("first_fit_extent_allocator_tb OK");
    else
      $display("first_fit_extent_allocator_tb NOT OK");
    $finish;
  end

endmodule

[filelist.f]
rtl/ffea_pkg.sv
rtl/ffea_req_if.sv
rtl/ffea_rsp_if.sv
rtl/ffea_cell.sv
rtl/first_fit_extent_allocator.sv
test/first_fit_extent_allocator_tb.sv
